/* src/ucf_pkg.sv */
// shared types, constants and folding function of the utf-8 case folding stream
// no dependencies
package ucf_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] LEAD2_MIN     = 8'hC2;
    localparam logic [7:0] LEAD2_MAX     = 8'hDF;
    localparam logic [7:0] LEAD3_MIN     = 8'hE0;
    localparam logic [7:0] LEAD3_MAX     = 8'hEF;
    localparam logic [7:0] LEAD4_MIN     = 8'hF0;
    localparam logic [7:0] LEAD4_MAX     = 8'hF4;
    localparam logic [7:0] LEAD_E0       = 8'hE0;
    localparam logic [7:0] LEAD_ED       = 8'hED;
    localparam logic [7:0] LEAD_F0       = 8'hF0;
    localparam logic [7:0] LEAD_F4       = 8'hF4;
    localparam logic [7:0] CONT_MIN      = 8'h80;
    localparam logic [7:0] CONT_MAX      = 8'hBF;
    localparam logic [7:0] CONT_MIN_E0   = 8'hA0;
    localparam logic [7:0] CONT_MAX_ED   = 8'h9F;
    localparam logic [7:0] CONT_MIN_F0   = 8'h90;
    localparam logic [7:0] CONT_MAX_F4   = 8'h8F;
    localparam logic [7:0] CONT_MARK     = 8'h80;
    localparam logic [7:0] LEAD2_MARK    = 8'hC0;
    localparam logic [7:0] LEAD3_MARK    = 8'hE0;
    localparam logic [7:0] LEAD4_MARK    = 8'hF0;

    localparam logic [20:0] CP_UPPER_A   = 21'h000041;
    localparam logic [20:0] CP_UPPER_Z   = 21'h00005A;
    localparam logic [20:0] CP_LOWER_A   = 21'h000061;
    localparam logic [20:0] CP_LOWER_Z   = 21'h00007A;
    localparam logic [20:0] CP_CYR_UP_LO = 21'h000410;
    localparam logic [20:0] CP_CYR_UP_HI = 21'h00042F;
    localparam logic [20:0] CP_CYR_LO_LO = 21'h000430;
    localparam logic [20:0] CP_CYR_LO_HI = 21'h00044F;
    localparam logic [20:0] CP_YO_UPPER  = 21'h000401;
    localparam logic [20:0] CP_YO_LOWER  = 21'h000451;
    localparam logic [20:0] CASE_DELTA   = 21'h000020;

    localparam logic [2:0] SEQ_LEN_2 = 3'd2;
    localparam logic [2:0] SEQ_LEN_3 = 3'd3;
    localparam logic [2:0] SEQ_LEN_4 = 3'd4;

    typedef enum logic {
        FOLD_LOWER = 1'b0,
        FOLD_UPPER = 1'b1
    } fold_mode_t;

    // one group of output bytes caused by one input transaction
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [3:0]      raw;
        logic [2:0]      count;
        logic            text_end;
    } run_t;

    function automatic logic [20:0] fold_cp(input logic [20:0] cp, input fold_mode_t mode);
        logic [20:0] res;
        res = cp;
        if (mode == FOLD_LOWER) begin
            if ((cp >= CP_UPPER_A && cp <= CP_UPPER_Z) ||
                (cp >= CP_CYR_UP_LO && cp <= CP_CYR_UP_HI)) begin
                res = cp + CASE_DELTA;
            end else if (cp == CP_YO_UPPER) begin
                res = CP_YO_LOWER;
            end
        end else begin
            if ((cp >= CP_LOWER_A && cp <= CP_LOWER_Z) ||
                (cp >= CP_CYR_LO_LO && cp <= CP_CYR_LO_HI)) begin
                res = cp - CASE_DELTA;
            end else if (cp == CP_YO_LOWER) begin
                res = CP_YO_UPPER;
            end
        end
        return res;
    endfunction

endpackage

/* src/utf8_case_folding_stream.sv */
// top level of the utf-8 case folding stream
// depends on ucf_pkg, ucf_front, ucf_queue, ucf_back
//
// Takes one UTF-8 byte per transaction and, in the same cycle it is accepted, decodes it
// against the strict well-formed grammar and turns it into a run of zero to four output
// bytes (folded code point, or raw copies of a malformed or unfinished sequence). Runs go
// through a two-entry queue to a serialiser that sends one byte per cycle while m_ready is
// high, so the block sustains one input byte per cycle while each byte yields at most one
// output byte and m_ready stays high; the input stalls only once the queue is full. Each run
// is written to the queue when its input is accepted, then loaded from the queue head into
// the serialiser's current-run register before m_valid rises for it. fold_mode is set via
// cfg_we/cfg_wdata; the user must write it only while the block is idle (not enforced).
module utf8_case_folding_stream import ucf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_text_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_raw_copy,
    output logic       m_run_last,
    output logic       m_text_last
);

    fold_mode_t fold_mode_reg;
    logic       push, q_full, q_pop, q_not_empty;
    run_t       push_run, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_mode_reg <= FOLD_LOWER;
        end else if (cfg_we) begin
            fold_mode_reg <= fold_mode_t'(cfg_wdata);
        end
    end

    assign s_ready = !q_full;

    ucf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fold_mode     (fold_mode_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_in_text_end (s_in_text_end),
        .push          (push),
        .push_run      (push_run)
    );

    ucf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_run  (push_run),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_run  (q_head)
    );

    ucf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_raw_copy  (m_raw_copy),
        .m_run_last  (m_run_last),
        .m_text_last (m_text_last)
    );

endmodule

/* src/ucf_front.sv */
// decoder front end: accepts bytes, tracks the open sequence, builds output runs
// depends on ucf_pkg
module ucf_front import ucf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  fold_mode_t fold_mode,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_text_end,
    output logic       push,
    output run_t       push_run
);

    logic [7:0]  pend_reg [3];
    logic [1:0]  cnt_reg, cnt_next;
    logic [2:0]  exp_reg, exp_next;
    logic [14:0] part_reg, part_next;

    logic        accept, open_seq, in_rng, complete, extend, fail_seq;
    logic        is_ascii, is_lead2, is_lead3, is_lead4, is_lead, include_b;
    logic [7:0]  lo, hi, bval, b;
    logic [1:0]  cnt_eff;
    logic [20:0] cp_full, folded, ascii_folded;
    run_t        run;

    always_comb begin
        b        = s_in_byte;
        accept   = s_valid && s_ready;
        open_seq = (cnt_reg != 2'd0);

        lo = CONT_MIN;
        hi = CONT_MAX;
        if (cnt_reg == 2'd1) begin
            case (pend_reg[0])
                LEAD_E0: lo = CONT_MIN_E0;
                LEAD_ED: hi = CONT_MAX_ED;
                LEAD_F0: lo = CONT_MIN_F0;
                LEAD_F4: hi = CONT_MAX_F4;
                default: ;
            endcase
        end
        in_rng = (b >= lo) && (b <= hi);

        is_ascii = (b < ASCII_LIMIT);
        is_lead2 = b inside {[LEAD2_MIN:LEAD2_MAX]};
        is_lead3 = b inside {[LEAD3_MIN:LEAD3_MAX]};
        is_lead4 = b inside {[LEAD4_MIN:LEAD4_MAX]};
        is_lead  = is_lead2 || is_lead3 || is_lead4;

        cp_full  = {part_reg, b[5:0]};
        complete = open_seq && in_rng && (({1'b0, cnt_reg} + 3'd1) >= exp_reg);
        extend   = open_seq && in_rng && !complete;
        fail_seq = open_seq && !in_rng;

        folded       = fold_cp(cp_full, fold_mode);
        ascii_folded = fold_cp({13'd0, b}, fold_mode);
        bval         = is_ascii ? ascii_folded[7:0] : b;
        cnt_eff      = (fail_seq || (extend && s_in_text_end)) ? cnt_reg : 2'd0;
        include_b    = extend ? s_in_text_end : (!is_lead || s_in_text_end);

        run          = '0;
        run.text_end = s_in_text_end;
        if (complete) begin
            run.count = exp_reg;
            case (exp_reg)
                SEQ_LEN_2: begin
                    run.bytes[0] = LEAD2_MARK | {3'd0, folded[10:6]};
                    run.bytes[1] = CONT_MARK | {2'd0, folded[5:0]};
                end
                SEQ_LEN_3: begin
                    run.bytes[0] = LEAD3_MARK | {4'd0, folded[15:12]};
                    run.bytes[1] = CONT_MARK | {2'd0, folded[11:6]};
                    run.bytes[2] = CONT_MARK | {2'd0, folded[5:0]};
                end
                default: begin
                    run.bytes[0] = LEAD4_MARK | {5'd0, folded[20:18]};
                    run.bytes[1] = CONT_MARK | {2'd0, folded[17:12]};
                    run.bytes[2] = CONT_MARK | {2'd0, folded[11:6]};
                    run.bytes[3] = CONT_MARK | {2'd0, folded[5:0]};
                end
            endcase
        end else begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < cnt_eff) begin
                    run.bytes[i] = pend_reg[i];
                    run.raw[i]   = 1'b1;
                end else begin
                    run.bytes[i] = bval;
                    run.raw[i]   = !is_ascii;
                end
            end
            run.bytes[3] = bval;
            run.raw[3]   = !is_ascii;
            run.count    = {1'b0, cnt_eff} + {2'd0, include_b};
        end

        cnt_next  = cnt_reg;
        exp_next  = exp_reg;
        part_next = part_reg;
        if (accept) begin
            if (complete || (extend && s_in_text_end)) begin
                cnt_next  = 2'd0;
                exp_next  = 3'd0;
                part_next = '0;
            end else if (extend) begin
                cnt_next  = cnt_reg + 2'd1;
                part_next = cp_full[14:0];
            end else if (is_lead && !s_in_text_end) begin
                cnt_next = 2'd1;
                if (is_lead2) begin
                    exp_next  = SEQ_LEN_2;
                    part_next = {10'd0, b[4:0]};
                end else if (is_lead3) begin
                    exp_next  = SEQ_LEN_3;
                    part_next = {11'd0, b[3:0]};
                end else begin
                    exp_next  = SEQ_LEN_4;
                    part_next = {12'd0, b[2:0]};
                end
            end else begin
                cnt_next  = 2'd0;
                exp_next  = 3'd0;
                part_next = '0;
            end
        end
    end

    assign push     = accept && (run.count != 3'd0);
    assign push_run = run;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            exp_reg  <= 3'd0;
            part_reg <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            exp_reg  <= exp_next;
            part_reg <= part_next;
        end
    end

    // buffered bytes of the open sequence
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (extend && !s_in_text_end) begin
                pend_reg[cnt_reg] <= b;
            end else if (!open_seq || fail_seq) begin
                pend_reg[0] <= b;
            end
        end
    end

endmodule

/* src/ucf_queue.sv */
// short run queue between the decoder front end and the output serialiser
// depends on ucf_pkg
module ucf_queue import ucf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  run_t push_run,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output run_t head_run
);

    run_t                   store_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_run  = store_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_run;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("run queue count beyond depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("run queue lost a transaction");

    a_pushed_run_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |-> (push_run.count != 3'd0 && push_run.count <= 3'd4))
        else $error("empty or oversized run queued");

endmodule

/* src/ucf_back.sv */
// output serialiser: sends the bytes of each queued run, one per transaction
// depends on ucf_pkg
module ucf_back import ucf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  run_t       q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_raw_copy,
    output logic       m_run_last,
    output logic       m_text_last
);

    run_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       last, advance;

    always_comb begin
        last    = (({1'b0, idx_reg} + 3'd1) == cur_reg.count);
        advance = !cur_valid_reg || (m_ready && last);
        q_pop   = advance && q_not_empty;

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (advance) begin
            cur_valid_next = q_not_empty;
            cur_next       = q_head;
            idx_next       = 2'd0;
        end else if (m_ready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    assign m_valid     = cur_valid_reg;
    assign m_out_byte  = cur_reg.bytes[idx_reg];
    assign m_raw_copy  = cur_reg.raw[idx_reg];
    assign m_run_last  = last;
    assign m_text_last = last && cur_reg.text_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

    a_idx_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> ({1'b0, idx_reg} < cur_reg.count))
        else $error("byte index past end of run");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_run_last) |=> (cur_valid_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("run cut short");

    a_pop_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!cur_valid_reg || (m_ready && m_run_last)))
        else $error("run loaded over an unfinished one");

endmodule
